[hdl/fce_pkg.sv]
// Shared types and constants for the flash controller unlock/erase block.
package fce_pkg;

  typedef logic [3:0] word_idx_t;

  localparam logic [31:0] KEY_ONE     = 32'h4567_0123;
  localparam logic [31:0] KEY_TWO     = 32'hcdef_89ab;
  localparam logic [31:0] OPT_KEY_ONE = 32'h0819_2a3b;
  localparam logic [31:0] OPT_KEY_TWO = 32'h4c5d_6e7f;

  localparam word_idx_t W_KEY     = 4'd2;
  localparam word_idx_t W_OPTKEY  = 4'd3;
  localparam word_idx_t W_STATUS  = 4'd4;
  localparam word_idx_t W_CONTROL = 4'd5;

  localparam int BIT_LOCK    = 31;
  localparam int BIT_OPTLOCK = 30;
  localparam int BIT_BUSY    = 16;
  localparam int BIT_EOP     = 0;
  localparam int BIT_PER     = 1;
  localparam int BIT_BANK    = 11;
  localparam int BIT_START   = 16;
  localparam int PAGE_LSB    = 3;
  localparam int PAGE_BITS   = 7;

  localparam logic [31:0] CONTROL_RESET = 32'hc000_0000;

  localparam logic [1:0] CFG_FLASH_BASE = 2'd0;
  localparam logic [1:0] CFG_BANK_SIZE  = 2'd1;
  localparam logic [1:0] CFG_PAGE_SIZE  = 2'd2;

  localparam logic [31:0] FLASH_BASE_RESET = 32'h0800_0000;
  localparam logic [31:0] BANK_SIZE_RESET  = 32'h0004_0000;
  localparam logic [31:0] PAGE_SIZE_RESET  = 32'h0000_0800;

  typedef struct packed {
    logic [31:0] flash_base;
    logic [31:0] bank_size;
    logic [31:0] page_size;
  } cfg_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        erase_request;
    logic [31:0] erase_address;
  } result_t;

endpackage

[hdl/fce_cfg.sv]
// APB configuration registers: flash base, bank size, page size.
module fce_cfg
  import fce_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t regs;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.flash_base <= FLASH_BASE_RESET;
      regs.bank_size  <= BANK_SIZE_RESET;
      regs.page_size  <= PAGE_SIZE_RESET;
    end else if (wr_en) begin
      case (paddr[3:2])
        CFG_FLASH_BASE: regs.flash_base <= pwdata;
        CFG_BANK_SIZE:  regs.bank_size  <= pwdata;
        CFG_PAGE_SIZE:  regs.page_size  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      CFG_FLASH_BASE: prdata = regs.flash_base;
      CFG_BANK_SIZE:  prdata = regs.bank_size;
      CFG_PAGE_SIZE:  prdata = regs.page_size;
      default:        prdata = '0;
    endcase
  end

endmodule

[hdl/fce_core.sv]
// Register words, key sequencers and erase address for one bus word per cycle while go is high.
module fce_core
  import fce_pkg::*;
#(
  parameter int REGISTER_WORDS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic        mode,
  input  logic [5:0]  offset,
  input  logic [31:0] wdata,
  input  logic [31:0] wmask,
  input  logic        erase_ok,
  input  cfg_t        cfg,
  output result_t     res
);

  localparam int STORED = (REGISTER_WORDS < 16) ? REGISTER_WORDS : 16;
  localparam int WIDX   = $clog2(STORED);
  localparam logic [WIDX-1:0] I_STATUS  = WIDX'(W_STATUS);
  localparam logic [WIDX-1:0] I_CONTROL = WIDX'(W_CONTROL);

  logic [31:0] words      [STORED];
  logic [31:0] words_next [STORED];
  logic        key_progress, key_progress_next;
  logic        opt_progress, opt_progress_next;

  word_idx_t       w;
  logic [WIDX-1:0] wi;
  logic            in_range;
  logic [31:0]     old, merged, ctrl_old;
  logic            bank;
  logic [PAGE_BITS-1:0] page;
  logic [31:0]     page_off;
  logic [31:0]     target;

  assign w        = offset[5:2];
  assign wi       = w[WIDX-1:0];
  assign in_range = ({28'b0, w} < 32'(STORED));
  assign old      = words[wi];
  assign merged   = (old & ~wmask) | (wdata & wmask);
  assign ctrl_old = words[I_CONTROL];

  assign bank     = merged[BIT_BANK];
  assign page     = merged[PAGE_LSB +: PAGE_BITS];
  assign page_off = 32'(page) * cfg.page_size;
  assign target   = cfg.flash_base + (bank ? cfg.bank_size : 32'b0) + page_off;

  always_comb begin
    words_next        = words;
    key_progress_next = key_progress;
    opt_progress_next = opt_progress;
    res               = '0;
    if (!mode) begin
      if (in_range && w != W_KEY && w != W_OPTKEY) begin
        if (w == W_STATUS) begin
          words_next[I_STATUS][BIT_BUSY] = 1'b0;
          res.rdata = old & ~(32'b1 << BIT_BUSY);
        end else begin
          res.rdata = old;
        end
      end
    end else if (in_range) begin
      case (w)
        W_KEY: begin
          if (wdata == KEY_ONE) begin
            key_progress_next = 1'b1;
          end else if (key_progress && wdata == KEY_TWO) begin
            words_next[I_CONTROL][BIT_LOCK] = 1'b0;
            key_progress_next = 1'b0;
          end else begin
            key_progress_next = 1'b0;
          end
          words_next[wi] = '0;
        end
        W_OPTKEY: begin
          if (wdata == OPT_KEY_ONE) begin
            opt_progress_next = 1'b1;
          end else if (opt_progress && wdata == OPT_KEY_TWO) begin
            words_next[I_CONTROL][BIT_OPTLOCK] = 1'b0;
            opt_progress_next = 1'b0;
          end else begin
            opt_progress_next = 1'b0;
          end
          words_next[wi] = '0;
        end
        W_STATUS: begin
          words_next[I_STATUS] = old & ~(wdata & wmask) & ~(32'b1 << BIT_BUSY);
        end
        W_CONTROL: begin
          if (!ctrl_old[BIT_LOCK]) begin
            words_next[I_CONTROL] = merged;
            if (merged[BIT_PER] && merged[BIT_START]) begin
              res.erase_request = 1'b1;
              res.erase_address = target;
              words_next[I_STATUS][BIT_BUSY] = 1'b0;
              if (erase_ok) begin
                words_next[I_STATUS][BIT_EOP] = 1'b1;
              end
            end
          end
        end
        default: begin
          words_next[wi] = merged;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STORED; i++) begin
        words[i] <= (i == int'(I_CONTROL)) ? CONTROL_RESET : '0;
      end
      key_progress     <= 1'b0;
      opt_progress     <= 1'b0;
    end else if (go) begin
      words        <= words_next;
      key_progress <= key_progress_next;
      opt_progress <= opt_progress_next;
    end
  end

  a_erase_unlocked: assert property (@(posedge clk) disable iff (rst)
    go && res.erase_request |-> !ctrl_old[BIT_LOCK])
    else $error("erase requested while control locked");

  a_busy_clear: assert property (@(posedge clk) disable iff (rst)
    !words[I_STATUS][BIT_BUSY])
    else $error("status busy bit visible");

  a_unlock_by_key: assert property (@(posedge clk) disable iff (rst)
    $fell(words[I_CONTROL][BIT_LOCK]) |-> $past(go && mode && w == W_KEY && key_progress))
    else $error("control lock cleared without key sequence");

  a_locked_holds: assert property (@(posedge clk) disable iff (rst)
    go && mode && w == W_CONTROL && ctrl_old[BIT_LOCK]
    |=> words[I_CONTROL] == $past(words[I_CONTROL]))
    else $error("locked control word changed on write");

endmodule

[hdl/flash_controller_unlock_erase.sv]
// Top level: flash controller register block with key unlock and page erase.
// A word goes through the input register, then the result register, to its result word.
// Throughput: one word per cycle unless stalled; the register file update and erase address
// (one 7x32 multiply and two adds) are done in the single stage after the input register.
// Reset (synchronous): pipeline empty, control word C0000000, other words and key
// progress zero, configuration registers back to their defaults.
module flash_controller_unlock_erase
  import fce_pkg::*;
#(
  parameter int REGISTER_WORDS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        access_valid,
  output logic        access_stall,
  input  logic        mode,
  input  logic [5:0]  offset,
  input  logic [31:0] wdata,
  input  logic [31:0] wmask,
  input  logic        erase_ok,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] rdata,
  output logic        erase_request,
  output logic [31:0] erase_address,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t    cfg;
  result_t res;
  result_t result;

  logic        item_valid;
  logic        item_mode;
  logic [5:0]  item_offset;
  logic [31:0] item_wdata;
  logic [31:0] item_wmask;
  logic        item_erase_ok;
  logic        out_adv;
  logic        go;

  assign out_adv      = !result_valid || !result_stall;
  assign access_stall = item_valid && !out_adv;
  assign go           = item_valid && out_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || out_adv) begin
      item_valid <= access_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (access_valid && !access_stall) begin
      item_mode     <= mode;
      item_offset   <= offset;
      item_wdata    <= wdata;
      item_wmask    <= wmask;
      item_erase_ok <= erase_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_adv) begin
      result_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      result <= res;
    end
  end

  assign rdata         = result.rdata;
  assign erase_request = result.erase_request;
  assign erase_address = result.erase_address;

  fce_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fce_core #(
    .REGISTER_WORDS (REGISTER_WORDS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .go       (go),
    .mode     (item_mode),
    .offset   (item_offset),
    .wdata    (item_wdata),
    .wmask    (item_wmask),
    .erase_ok (item_erase_ok),
    .cfg      (cfg),
    .res      (res)
  );

endmodule
